### rtl/isbi_pkg.sv
// Shared types, constants and codes of the image sampler.
`default_nettype none
package isbi_pkg;

	// Tap coordinate: integer pixel position, wide enough for the reflect arithmetic.
	localparam int CoordW = 14;
	typedef logic signed [CoordW-1:0] coord_t;

	// Steps of the bit-serial modulo unit: a load step, then one step per magnitude
	// bit of a tap base coordinate.
	localparam int ModSteps = 12;

	// Configuration register indexes.
	localparam logic [2:0] REG_WIDTH        = 3'd0;
	localparam logic [2:0] REG_HEIGHT       = 3'd1;
	localparam logic [2:0] REG_METHOD       = 3'd2;
	localparam logic [2:0] REG_BORDER_MODE  = 3'd3;
	localparam logic [2:0] REG_BORDER_VALUE = 3'd4;

	// Interpolation methods; the unused code acts as bilinear.
	localparam logic [1:0] METHOD_NEAREST  = 2'd0;
	localparam logic [1:0] METHOD_BILINEAR = 2'd1;
	localparam logic [1:0] METHOD_BICUBIC  = 2'd2;

	// Border modes; the unused codes act as constant.
	localparam logic [2:0] BORDER_CONSTANT   = 3'd0;
	localparam logic [2:0] BORDER_REPLICATE  = 3'd1;
	localparam logic [2:0] BORDER_REFLECT    = 3'd2;
	localparam logic [2:0] BORDER_REFLECT101 = 3'd3;
	localparam logic [2:0] BORDER_WRAP       = 3'd4;

	// Request opcodes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// One mapped tap position on one axis.
	typedef struct packed {
		logic [7:0] idx;
		logic       border;
	} tap_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_MAP,
		ST_RUN,
		ST_DRAIN,
		ST_ABS,
		ST_ROUND
	} state_t;

endpackage
`default_nettype wire

### rtl/isbi_stream_if.sv
// Request and response channel interfaces of the image sampler.
`default_nettype none
interface isbi_req_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [7:0]        write_col;
	logic [7:0]        write_row;
	logic [7:0]        write_value;
	logic signed [18:0] sample_x;
	logic signed [18:0] sample_y;

	modport source(output valid, opcode, write_col, write_row, write_value, sample_x,
		sample_y, input ready);
	modport sink(input valid, opcode, write_col, write_row, write_value, sample_x,
		sample_y, output ready);
endinterface

interface isbi_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample_value;
	logic       saturated;

	modport source(output valid, sample_value, saturated, input ready);
	modport sink(input valid, sample_value, saturated, output ready);
endinterface
`default_nettype wire

### rtl/image_sampler_border_interp_core.sv
// Image sampler: pixel store, border mapping and nearest/bilinear/bicubic interpolation.
// A sample passes through the modulo unit and a mapping state, then reads one tap per cycle
// (1 nearest, 4 bilinear, 16 bicubic) from the single-port image memory, and then drains
// and rounds to the result. A new request is taken once the previous sample has reached
// the output register.
// Reset clears control state and the configuration registers; the image memory is not cleared.
`default_nettype none
module image_sampler_border_interp_core import isbi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	isbi_req_if.sink    req,
	isbi_rsp_if.source  rsp
);

	// Configuration
	logic [8:0] width_q, height_q;
	logic [1:0] method_q;
	logic [2:0] bmode_q;
	logic [7:0] bval_q;
	logic [8:0] w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			method_q <= METHOD_BILINEAR;
			bmode_q  <= BORDER_CONSTANT;
			bval_q   <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:        width_q  <= cfg_wdata;
				REG_HEIGHT:       height_q <= cfg_wdata;
				REG_METHOD:       method_q <= cfg_wdata[1:0];
				REG_BORDER_MODE:  bmode_q  <= cfg_wdata[2:0];
				REG_BORDER_VALUE: bval_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (width_q == 9'd0) ? 9'd1 : ((width_q > 9'd256) ? 9'd256 : width_q);
		h_eff = (height_q == 9'd0) ? 9'd1 : ((height_q > 9'd256) ? 9'd256 : height_q);
	end

	// Control
	state_t state_q, state_d;
	logic   in_ready, mod_step, map_load, rd_en, out_load, out_free, last_tap;
	logic   acc_req, mem_we;
	logic   v_s1, v_s2;
	logic [3:0] mcnt_q;
	logic [1:0] ti_q, tj_q, ilo_q, ihi_q;
	logic   rsp_valid_q;

	assign acc_req  = req.valid && req.ready;
	assign mem_we   = acc_req && (req.opcode == OP_WRITE);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign last_tap = (ti_q == ihi_q) && (tj_q == ihi_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc_req && req.opcode == OP_SAMPLE) state_d = ST_MOD;
			ST_MOD:   if (mcnt_q == 4'(ModSteps - 1)) state_d = ST_MAP;
			ST_MAP:   state_d = ST_RUN;
			ST_RUN:   if (last_tap) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_ABS;
			ST_ABS:   state_d = ST_ROUND;
			ST_ROUND: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mod_step = (state_q == ST_MOD);
		map_load = (state_q == ST_MAP);
		rd_en    = (state_q == ST_RUN);
		out_load = (state_q == ST_ROUND) && out_free;
	end

	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture
	coord_t    bx_q, by_q;
	logic [7:0] fx_q, fy_q;
	logic [1:0] meth_q;

	function automatic coord_t round_coord(input logic signed [18:0] v);
		logic signed [19:0] e;
		logic [19:0]        mag;
		coord_t             r;
		e   = 20'(v);
		mag = e[19] ? 20'(-e) : 20'(e);
		mag = mag + 20'd128;
		r   = coord_t'({2'b00, mag[19:8]});
		return e[19] ? -r : r;
	endfunction

	always_ff @(posedge clk) begin
		if (acc_req && req.opcode == OP_SAMPLE) begin
			meth_q <= method_q;
			if (method_q == METHOD_NEAREST) begin
				bx_q <= round_coord(req.sample_x);
				by_q <= round_coord(req.sample_y);
				fx_q <= 8'd0;
				fy_q <= 8'd0;
			end else begin
				bx_q <= coord_t'(signed'(req.sample_x[18:8]));
				by_q <= coord_t'(signed'(req.sample_y[18:8]));
				fx_q <= req.sample_x[7:0];
				fy_q <= req.sample_y[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ilo_q <= 2'd1;
			ihi_q <= 2'd1;
		end else if (acc_req && req.opcode == OP_SAMPLE) begin
			unique case (method_q)
				METHOD_NEAREST: begin
					ilo_q <= 2'd1;
					ihi_q <= 2'd1;
				end
				METHOD_BICUBIC: begin
					ilo_q <= 2'd0;
					ihi_q <= 2'd3;
				end
				default: begin
					ilo_q <= 2'd1;
					ihi_q <= 2'd2;
				end
			endcase
		end
	end

	// Bit-serial modulo of the base coordinates by the image size, for wrap mode.
	logic [10:0] mmag_q [2];
	logic [7:0]  rem_q  [2];
	logic        mneg_q [2];
	logic [8:0]  msize  [2];
	logic [8:0]  mtry   [2];
	logic [7:0]  bmod   [2];
	coord_t      mbase  [2];

	always_comb begin
		mbase[0] = bx_q;
		mbase[1] = by_q;
		msize[0] = w_eff;
		msize[1] = h_eff;
		for (int a = 0; a < 2; a++) begin
			mtry[a] = {rem_q[a], mmag_q[a][10]};
			if (mtry[a] >= msize[a]) begin
				mtry[a] = mtry[a] - msize[a];
			end
			bmod[a] = (mneg_q[a] && rem_q[a] != 8'd0) ? 8'(msize[a] - {1'b0, rem_q[a]})
				: rem_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (state_q == ST_IDLE) begin
			mcnt_q <= '0;
		end else if (mod_step) begin
			mcnt_q <= mcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			if (state_q == ST_IDLE) begin
				// The base is captured in the same cycle; load it in the first modulo step.
				rem_q[a] <= '0;
			end else if (mod_step) begin
				if (mcnt_q == 4'd0) begin
					mneg_q[a] <= mbase[a][CoordW-1];
					mmag_q[a] <= mbase[a][CoordW-1] ? 11'(-mbase[a]) : 11'(mbase[a]);
					rem_q[a]  <= '0;
				end else begin
					rem_q[a]  <= mtry[a][7:0];
					mmag_q[a] <= {mmag_q[a][9:0], 1'b0};
				end
			end
		end
	end

	// Cubic weights, two register stages per lane; lanes 0..3 for x, 4..7 for y.
	logic [9:0]         tdist [8];
	logic signed [12:0] ds    [8];
	logic signed [12:0] acoef [8];
	logic signed [23:0] p1    [8];
	logic [9:0]         d_s1  [8];
	logic               c2_s1 [8];
	logic signed [23:0] p1_s1 [8];
	logic signed [23:0] tt    [8];
	logic signed [10:0] dd    [8];
	logic signed [34:0] wsum  [8];
	logic signed [26:0] wc_s2 [8];

	always_comb begin
		tdist[0] = {2'b0, fx_q} + 10'd256;
		tdist[1] = {2'b0, fx_q};
		tdist[2] = 10'd256 - {2'b0, fx_q};
		tdist[3] = 10'd512 - {2'b0, fx_q};
		tdist[4] = {2'b0, fy_q} + 10'd256;
		tdist[5] = {2'b0, fy_q};
		tdist[6] = 10'd256 - {2'b0, fy_q};
		tdist[7] = 10'd512 - {2'b0, fy_q};
		for (int k = 0; k < 8; k++) begin
			ds[k]    = signed'({3'b0, tdist[k]});
			acoef[k] = (tdist[k] < 10'd256) ? ds[k] * 13'sd3 - 13'sd1280 : 13'sd1280 - ds[k];
			p1[k]    = 24'(ds[k]) * 24'(acoef[k]);
			tt[k]    = c2_s1[k] ? p1_s1[k] - 24'sd524288 : p1_s1[k];
			dd[k]    = signed'({1'b0, d_s1[k]});
			wsum[k]  = tt[k] * dd[k] + (c2_s1[k] ? 35'sd67108864 : 35'sd33554432);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			d_s1[k]  <= tdist[k];
			c2_s1[k] <= (tdist[k] >= 10'd256);
			p1_s1[k] <= p1[k];
			wc_s2[k] <= (d_s1[k] >= 10'd512) ? 27'sd0 : 27'(wsum[k]);
		end
	end

	// Tap mapping and per-axis weights, latched for the tap loop.
	tap_t               tmx [4], tmy [4];
	tap_t               tapx_q [4], tapy_q [4];
	logic signed [26:0] wx_q [4], wy_q [4];

	for (genvar g = 0; g < 4; g++) begin : g_map
		isbi_axis_map u_mx (
			.base     (bx_q),
			.offs     (2'(g)),
			.size     (w_eff),
			.mode     (bmode_q),
			.base_mod (bmod[0]),
			.tap      (tmx[g])
		);
		isbi_axis_map u_my (
			.base     (by_q),
			.offs     (2'(g)),
			.size     (h_eff),
			.mode     (bmode_q),
			.base_mod (bmod[1]),
			.tap      (tmy[g])
		);
	end

	function automatic logic signed [26:0] pick_weight(input logic [1:0] meth,
		input int unsigned i, input logic [7:0] f, input logic signed [26:0] wc);
		logic signed [26:0] w;
		w = 27'sd0;
		unique case (meth)
			METHOD_NEAREST: if (i == 1) w = 27'sd33554432;
			METHOD_BICUBIC: w = wc;
			default: begin
				if (i == 1) w = signed'({1'b0, 9'd256 - {1'b0, f}, 17'd0});
				if (i == 2) w = signed'({2'b0, f, 17'd0});
			end
		endcase
		return w;
	endfunction

	always_ff @(posedge clk) begin
		if (map_load) begin
			for (int i = 0; i < 4; i++) begin
				tapx_q[i] <= tmx[i];
				tapy_q[i] <= tmy[i];
				wx_q[i]   <= pick_weight(meth_q, i, fx_q, wc_s2[i]);
				wy_q[i]   <= pick_weight(meth_q, i, fy_q, wc_s2[i+4]);
			end
		end
	end

	// Tap loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q <= 2'd1;
			tj_q <= 2'd1;
		end else if (map_load) begin
			ti_q <= ilo_q;
			tj_q <= ilo_q;
		end else if (rd_en && !last_tap) begin
			if (ti_q == ihi_q) begin
				ti_q <= ilo_q;
				tj_q <= tj_q + 2'd1;
			end else begin
				ti_q <= ti_q + 2'd1;
			end
		end
	end

	// Image memory, single port
	logic [7:0]  mem [0:65535];
	logic [15:0] maddr;
	logic [7:0]  rd_s1;

	assign maddr = mem_we ? {req.write_row, req.write_col}
		: {tapy_q[tj_q].idx, tapx_q[ti_q].idx};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[maddr] <= req.write_value;
		end
		rd_s1 <= mem[maddr];
	end

	// Multiply-accumulate pipeline
	logic               brd_s1;
	logic signed [53:0] wp_s1;
	logic signed [62:0] prod_s2;
	logic signed [63:0] acc_q;
	logic [7:0]         pix;

	assign pix = brd_s1 ? bval_q : rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		brd_s1  <= tapx_q[ti_q].border || tapy_q[tj_q].border;
		wp_s1   <= 54'(wx_q[ti_q]) * 54'(wy_q[tj_q]);
		prod_s2 <= 63'(signed'({1'b0, pix})) * 63'(wp_s1);
		if (map_load) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + 64'(prod_s2);
		end
	end

	// Rounding half away from zero at scale 2^50, then saturation.
	logic        neg_q;
	logic [63:0] mag_q;
	logic [63:0] rsum;
	logic [13:0] q;
	logic [7:0]  val_q;
	logic        sat_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_ABS) begin
			neg_q <= acc_q[63];
			mag_q <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		end
	end

	always_comb begin
		rsum = mag_q + (64'd1 << 49);
		q    = rsum[63:50];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (neg_q) begin
				val_q <= 8'd0;
				sat_q <= (q != 14'd0);
			end else if (q > 14'd255) begin
				val_q <= 8'd255;
				sat_q <= 1'b1;
			end else begin
				val_q <= q[7:0];
				sat_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.sample_value = val_q;
	assign rsp.saturated    = sat_q;

	// Assertions
	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rd_en)
		else $error("pixel write collided with a tap read");

	a_tap_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (ti_q >= ilo_q && ti_q <= ihi_q && tj_q >= ilo_q
			&& tj_q <= ihi_q))
		else $error("tap counter left its window");

	a_out_from_round: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_ROUND)
		else $error("response raised outside the rounding state");

	a_drain_before_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ABS) |-> (!v_s1 && !v_s2))
		else $error("rounding started with taps in flight");

endmodule
`default_nettype wire

### rtl/isbi_axis_map.sv
// Maps one tap coordinate on one axis into the image according to the border mode.
`default_nettype none
module isbi_axis_map import isbi_pkg::*; (
	input  coord_t     base,
	input  logic [1:0] offs,
	input  logic [8:0] size,
	input  logic [2:0] mode,
	input  logic [7:0] base_mod,
	output tap_t       tap
);

	coord_t     c, sz, two, rf1, rf2, r1, r2, t;
	logic       in_img, const_mode;
	logic [9:0] bm, s10, wv;

	always_comb begin
		c   = base + coord_t'(signed'({1'b0, offs})) - coord_t'(1);
		sz  = coord_t'({5'b0, size});
		two = sz + sz;
		in_img = (c >= coord_t'(0)) && (c < sz);

		rf1 = (c < coord_t'(0)) ? -c - coord_t'(1) : c;
		rf2 = (rf1 >= sz) ? two - rf1 - coord_t'(1) : rf1;
		r1  = (c < coord_t'(0)) ? -c : c;
		r2  = (r1 >= sz) ? two - r1 - coord_t'(2) : r1;

		// Wrap steps from the base coordinate's residue, which the modulo unit supplies.
		bm  = {2'b0, base_mod};
		s10 = {1'b0, size};
		unique case (offs)
			2'd0: wv = (bm == 10'd0) ? s10 - 10'd1 : bm - 10'd1;
			2'd1: wv = bm;
			2'd2: wv = (bm + 10'd1 == s10) ? 10'd0 : bm + 10'd1;
			2'd3: begin
				wv = bm + 10'd2;
				if (wv >= s10 + s10) begin
					wv = wv - s10 - s10;
				end else if (wv >= s10) begin
					wv = wv - s10;
				end
			end
		endcase

		const_mode = 1'b0;
		unique case (mode)
			BORDER_REPLICATE:  t = c;
			BORDER_REFLECT:    t = rf2;
			BORDER_REFLECT101: t = r2;
			BORDER_WRAP:       t = coord_t'({4'b0, wv});
			default: begin
				t = c;
				const_mode = 1'b1;
			end
		endcase

		if (t < coord_t'(0)) begin
			t = coord_t'(0);
		end else if (t >= sz) begin
			t = sz - coord_t'(1);
		end

		tap.idx    = t[7:0];
		tap.border = !in_img && const_mode;
	end

endmodule
`default_nettype wire
